@@ rtl/core/giq_pkg.sv @@
// ----------------------------------------------------------------------------
// giq_pkg - shared types for the grouped insertion queue
// Entry, command and response beat layouts, status codes, per-cell control.
// ----------------------------------------------------------------------------
package giq_pkg;

    localparam int GIQ_QUEUE_DEPTH = 16;
    localparam int GIQ_PRIO_W      = 8;
    localparam int GIQ_ID_W        = 16;
    localparam int GIQ_FILL_W      = 5;

    localparam logic GIQ_CMD_INSERT = 1'b0;
    localparam logic GIQ_CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        GIQ_ST_OK    = 2'd0,
        GIQ_ST_FULL  = 2'd1,
        GIQ_ST_EMPTY = 2'd2
    } giq_status_t;

    typedef struct packed {
        logic [GIQ_PRIO_W-1:0] prio;
        logic [GIQ_ID_W-1:0]   id;
    } giq_entry_t;

    typedef struct packed {
        logic                  cmd;
        logic [GIQ_PRIO_W-1:0] user_priority;
        logic [GIQ_ID_W-1:0]   job_id;
    } giq_cmd_t;

    typedef struct packed {
        giq_status_t           status;
        logic [GIQ_PRIO_W-1:0] head_priority;
        logic [GIQ_ID_W-1:0]   head_id;
        logic [GIQ_FILL_W-1:0] fill_level;
    } giq_rsp_t;

    // Per-cell control, broadcast along the row with cell-local position bits
    typedef struct packed {
        logic do_insert;   // accepted insert, queue not full
        logic do_remove;   // accepted remove, queue not empty
        logic any_match;   // some held entry carries the new priority
        logic occupied;    // cell index below the fill count
        logic at_tail;     // cell index equals the fill count
        logic past_tail;   // cell index above the fill count
    } giq_cell_ctrl_t;

endpackage

@@ rtl/core/giq_cell.sv @@
// ----------------------------------------------------------------------------
// giq_cell - one slot of the grouped insertion queue
// Holds one entry, compares its priority with the new one and loads from
// the new entry, its left or its right neighbour.
// ----------------------------------------------------------------------------
module giq_cell
    import giq_pkg::*;
(
    input  logic           clk,
    input  giq_cell_ctrl_t ctrl,
    input  giq_entry_t     new_entry,
    input  giq_entry_t     left_entry,
    input  giq_entry_t     right_entry,
    input  logic           hit_in,
    input  logic           prev_match,
    output logic           match,
    output logic           hit,
    output giq_entry_t     entry
);

    giq_entry_t entry_reg;
    giq_entry_t entry_next;
    logic       prev_hit;
    logic       after_pos;
    logic       at_pos;

    assign match    = ctrl.occupied && (entry_reg.prio == new_entry.prio);
    // hit: a match somewhere at or behind this cell
    assign hit      = match | hit_in;
    assign prev_hit = prev_match | hit;

    assign after_pos = ctrl.any_match ? !prev_hit : ctrl.past_tail;
    assign at_pos    = ctrl.any_match ? (prev_match && !hit) : ctrl.at_tail;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.do_remove)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.do_insert)
        begin
            if (at_pos)
            begin
                entry_next = new_entry;
            end
            else if (after_pos)
            begin
                entry_next = left_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ rtl/core/grouped_insertion_queue.sv @@
// ----------------------------------------------------------------------------
// grouped_insertion_queue - bounded job queue with priority grouping
// Row of QUEUE_DEPTH cells, fill counter and registered response beat.
// ----------------------------------------------------------------------------
// An insert beat places its entry straight after the last held entry of the
// same priority, or at the tail if none has it; a remove beat pops the head.
// Every command beat gives one response beat carrying the status, the popped
// entry (zero unless a remove succeeded) and the fill level after the
// command. A command takes effect and loads its response into the output
// register at the clock edge that accepts it; one command per cycle is
// taken while the response side keeps up. The cycle is set by the insert
// path: a priority compare in every cell and the match ripple along the
// row of cells. The store needs no clearing after reset; only cells below
// the fill count take part in compares or are reported.
// ----------------------------------------------------------------------------
module grouped_insertion_queue
    import giq_pkg::*;
#(
    parameter int QUEUE_DEPTH = GIQ_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  giq_cmd_t cmd_data,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output giq_rsp_t rsp_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    giq_rsp_t         rsp_reg;
    giq_rsp_t         rsp_next;

    logic accept;
    logic is_full;
    logic is_empty;
    logic do_insert;
    logic do_remove;

    giq_entry_t new_entry;
    giq_entry_t cell_entry [QUEUE_DEPTH];
    logic       cell_match [QUEUE_DEPTH];
    logic       cell_hit   [QUEUE_DEPTH];

    // Response register frees up when empty or when its beat leaves
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign is_full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty  = (count_reg == '0);
    assign do_insert = accept && (cmd_data.cmd == GIQ_CMD_INSERT) && !is_full;
    assign do_remove = accept && (cmd_data.cmd == GIQ_CMD_REMOVE) && !is_empty;

    assign new_entry.prio = cmd_data.user_priority;
    assign new_entry.id   = cmd_data.job_id;

    // Row of cells; index 0 is the head
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        giq_cell_ctrl_t ctrl;
        giq_entry_t     left_entry;
        giq_entry_t     right_entry;
        logic           hit_in;
        logic           prev_match;

        assign ctrl.do_insert = do_insert;
        assign ctrl.do_remove = do_remove;
        assign ctrl.any_match = cell_hit[0];
        assign ctrl.occupied  = (CNT_W'(i) < count_reg);
        assign ctrl.at_tail   = (CNT_W'(i) == count_reg);
        assign ctrl.past_tail = (CNT_W'(i) > count_reg);

        if (i == 0)
        begin : g_head
            // head never takes from the left
            assign left_entry = new_entry;
            assign prev_match = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign prev_match = cell_match[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            // vacated last slot on a pop: contents no longer counted
            assign right_entry = cell_entry[i];
            assign hit_in      = 1'b0;
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
            assign hit_in      = cell_hit[i+1];
        end

        giq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .hit_in      (hit_in),
            .prev_match  (prev_match),
            .match       (cell_match[i]),
            .hit         (cell_hit[i]),
            .entry       (cell_entry[i])
        );
    end

    // Fill count
    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Response beat
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (accept)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.status        = GIQ_ST_OK;
            rsp_next.head_priority = '0;
            rsp_next.head_id       = '0;
            rsp_next.fill_level    = GIQ_FILL_W'(count_next);
            if (cmd_data.cmd == GIQ_CMD_INSERT)
            begin
                if (is_full)
                begin
                    rsp_next.status = GIQ_ST_FULL;
                end
            end
            else if (is_empty)
            begin
                rsp_next.status = GIQ_ST_EMPTY;
            end
            else
            begin
                rsp_next.head_priority = cell_entry[0].prio;
                rsp_next.head_id       = cell_entry[0].id;
            end
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the grouped insertion queue
// A clocked driver feeds command beats from a backlog that the stimulus
// block fills, and a clocked monitor predicts each accepted command and
// checks every response beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
    import giq_pkg::*;

    localparam int QUEUE_DEPTH    = GIQ_QUEUE_DEPTH;
    localparam int IDLE_PCT       = 9;     // chance of an idle cycle on either side
    localparam int LONG_HOLD      = 120;   // receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either channel
    localparam int DRAIN_TAIL     = 10;    // cycles past the last response
    localparam int MAX_REPORTS    = 10;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    giq_cmd_t cmd_data = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    giq_rsp_t rsp_data;

    grouped_insertion_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Stimulus and bookkeeping shared between processes
    giq_cmd_t cmd_backlog[$];
    giq_rsp_t awaited_rsps[$];
    int       cmds_issued  = 0;
    int       cmds_taken   = 0;
    int       beats_seen   = 0;
    int       rsps_checked = 0;
    int       mismatch_count = 0;
    logic     cmd_went = 1'b0;
    logic     no_idle  = 1'b0;
    int       hold_asked  = 0;
    int       hold_served = 0;
    int       hold_left   = 0;

    // Shadow copy of the queue
    giq_entry_t shadow_entries [QUEUE_DEPTH];
    int         shadow_count = 0;
    int         full_drops   = 0;
    int         empty_pops   = 0;
    int         good_pops    = 0;
    int         deepest      = 0;

    // Applies one command to the shadow queue and returns the response it
    // should produce.
    function automatic giq_rsp_t next_queue_response(giq_cmd_t c);
        giq_rsp_t r;
        int       slot;
        r = '0;
        r.status = GIQ_ST_OK;
        if (c.cmd == GIQ_CMD_INSERT)
        begin
            if (shadow_count >= QUEUE_DEPTH)
            begin
                r.status = GIQ_ST_FULL;
                full_drops++;
            end
            else
            begin
                // tail by default, or just behind the last entry of the same class
                slot = shadow_count;
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_entries[i].prio == c.user_priority)
                        slot = i + 1;
                for (int i = shadow_count; i > slot; i--)
                    shadow_entries[i] = shadow_entries[i - 1];
                shadow_entries[slot].prio = c.user_priority;
                shadow_entries[slot].id   = c.job_id;
                shadow_count++;
                if (shadow_count > deepest)
                    deepest = shadow_count;
            end
        end
        else if (shadow_count == 0)
        begin
            r.status = GIQ_ST_EMPTY;
            empty_pops++;
        end
        else
        begin
            r.head_priority = shadow_entries[0].prio;
            r.head_id       = shadow_entries[0].id;
            for (int i = 0; i + 1 < shadow_count; i++)
                shadow_entries[i] = shadow_entries[i + 1];
            shadow_count--;
            good_pops++;
        end
        r.fill_level = GIQ_FILL_W'(shadow_count);
        return r;
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    // Driver: a new beat goes out at the falling edge once the previous one
    // was taken, so a stalled beat is never altered.
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_went))
        begin
            if (cmd_backlog.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
            begin
                cmd_valid <= 1'b1;
                cmd_data  <= cmd_backlog.pop_front();
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall, or a long hold-off when one is asked for
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (hold_asked != hold_served)
        begin
            hold_served <= hold_asked;
            hold_left   <= LONG_HOLD;
            rsp_stall   <= 1'b1;
        end
        else
        begin
            rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Monitor: response beats are checked before this edge's command is
    // predicted; the response register loads at the edge that takes its command.
    always @(posedge clk)
    begin : monitor
        giq_rsp_t want;
        if (!rst_n)
        begin
            cmd_went <= 1'b0;
        end
        else
        begin
            cmd_went <= cmd_valid && !cmd_stall;
            if (rsp_valid && !rsp_stall)
            begin
                beats_seen++;
                if (awaited_rsps.size() == 0)
                begin
                    flag_mismatch($sformatf("response beat with nothing outstanding: %p",
                                            rsp_data));
                end
                else
                begin
                    want = awaited_rsps.pop_front();
                    rsps_checked++;
                    if (rsp_data.status !== want.status
                        || rsp_data.head_priority !== want.head_priority
                        || rsp_data.head_id !== want.head_id
                        || rsp_data.fill_level !== want.fill_level)
                        flag_mismatch({
                            $sformatf("beat %0d expected st=%0d pr=%02h id=%04h fill=%0d",
                                      rsps_checked, want.status, want.head_priority,
                                      want.head_id, want.fill_level),
                            $sformatf(", got st=%0d pr=%02h id=%04h fill=%0d",
                                      rsp_data.status, rsp_data.head_priority,
                                      rsp_data.head_id, rsp_data.fill_level)});
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                beats_seen++;
                cmds_taken++;
                awaited_rsps.push_back(next_queue_response(cmd_data));
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long
    initial
    begin : watchdog
        int last_seen;
        int quiet;
        last_seen = 0;
        quiet     = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if (beats_seen != last_seen)
            begin
                last_seen = beats_seen;
                quiet     = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("[%0t] watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic push_cmd(logic op, logic [7:0] prio, logic [15:0] id);
        giq_cmd_t c;
        c.cmd           = op;
        c.user_priority = prio;
        c.job_id        = id;
        cmd_backlog.push_back(c);
        cmds_issued++;
    endtask

    // Sampled at the falling edge, where none of these counters move
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (cmds_taken != cmds_issued || awaited_rsps.size() != 0);
    endtask

    // Runs of commands biased towards filling, draining or neither, and mostly a
    // handful of priority classes so that grouping actually happens.
    task automatic random_runs(int count, int fixed_pct);
        int         run_len;
        int         insert_pct;
        logic [7:0] classes [4];
        logic       wide;
        logic       op;
        logic [7:0] prio;
        while (count > 0)
        begin
            run_len = $urandom_range(60, 10);
            case ($urandom_range(2))
                0: insert_pct = 15;
                1: insert_pct = 50;
                default: insert_pct = 85;
            endcase
            if (fixed_pct >= 0)
                insert_pct = fixed_pct;
            foreach (classes[k])
                classes[k] = 8'($urandom_range(255));
            wide = ($urandom_range(3) == 0);
            repeat (run_len)
            begin
                if (count > 0)
                begin
                    op   = ($urandom_range(99) < insert_pct) ? GIQ_CMD_INSERT : GIQ_CMD_REMOVE;
                    prio = wide ? 8'($urandom_range(255)) : classes[$urandom_range(3)];
                    push_cmd(op, prio, 16'($urandom_range(65535)));
                    count--;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        logic [7:0]  fill_prio [9];
        logic [15:0] fill_id   [9];
        fill_prio = '{8'h80, 8'h7F, 8'hAA, 8'h55, 8'h01, 8'hFE, 8'h80, 8'h00, 8'hFF};
        fill_id   = '{16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00, 16'h7FFF,
                      16'h8000, 16'h3C3C, 16'hC3C3, 16'h0002};

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed: pop on empty, grouping at front and middle, plain inserts at the
        // tail, then fill to the brim, one dropped insert, and a few pops.
        push_cmd(GIQ_CMD_REMOVE, 8'h00, 16'h0000);
        push_cmd(GIQ_CMD_INSERT, 8'h00, 16'h0000);
        push_cmd(GIQ_CMD_INSERT, 8'hFF, 16'hFFFF);
        push_cmd(GIQ_CMD_INSERT, 8'h00, 16'h1234);
        push_cmd(GIQ_CMD_INSERT, 8'hAA, 16'h5555);
        push_cmd(GIQ_CMD_INSERT, 8'h55, 16'hAAAA);
        push_cmd(GIQ_CMD_INSERT, 8'hFF, 16'h0001);
        push_cmd(GIQ_CMD_INSERT, 8'h00, 16'h8000);
        foreach (fill_prio[k])
            push_cmd(GIQ_CMD_INSERT, fill_prio[k], fill_id[k]);
        push_cmd(GIQ_CMD_INSERT, 8'h12, 16'h3456);
        push_cmd(GIQ_CMD_REMOVE, 8'hFF, 16'hFFFF);
        push_cmd(GIQ_CMD_REMOVE, 8'h00, 16'h0000);
        push_cmd(GIQ_CMD_INSERT, 8'h00, 16'hBEEF);
        push_cmd(GIQ_CMD_REMOVE, 8'h00, 16'h0000);
        wait_for_drain();

        random_runs(600, -1);
        wait_for_drain();

        // Stretch with no idling on either side
        no_idle = 1'b1;
        random_runs(400, -1);
        wait_for_drain();
        no_idle = 1'b0;

        // Receiver holds off while commands keep coming, so the block backs up
        hold_asked++;
        random_runs(300, 70);
        wait_for_drain();

        random_runs(650, -1);
        wait_for_drain();
        repeat (DRAIN_TAIL) @(negedge clk);

        if (awaited_rsps.size() != 0)
        begin
            mismatch_count += awaited_rsps.size();
            $display("%0d responses never arrived", awaited_rsps.size());
        end

        $display("Covered %0d commands, %0d responses checked; deepest fill %0d of %0d.",
                 cmds_taken, rsps_checked, deepest, QUEUE_DEPTH);
        $display("Pops %0d, dropped inserts when full %0d, pops on empty %0d, errors %0d.",
                 good_pops, full_drops, empty_pops, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/giq_pkg.sv
rtl/core/giq_cell.sv
rtl/core/grouped_insertion_queue.sv
tb/testbench.sv
